FILE: src/itp_pkg.sv
package itp_pkg;

  // Operator stack codes
  localparam logic [2:0] CODE_OPEN = 3'd0;
  localparam logic [2:0] CODE_ADD  = 3'd1;
  localparam logic [2:0] CODE_SUB  = 3'd2;
  localparam logic [2:0] CODE_MUL  = 3'd3;
  localparam logic [2:0] CODE_DIV  = 3'd4;
  localparam logic [2:0] CODE_POW  = 3'd5;

  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_ADD    = 8'h2B;
  localparam logic [7:0] CH_SUB    = 8'h2D;
  localparam logic [7:0] CH_MUL    = 8'h2A;
  localparam logic [7:0] CH_DIV    = 8'h2F;
  localparam logic [7:0] CH_POW    = 8'h5E;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;
  localparam logic [7:0] CH_NUL    = 8'h00;

  function automatic logic [7:0] code_char(input logic [2:0] code);
    logic [7:0] ch;
    unique case (code)
      CODE_OPEN: ch = CH_LPAREN;
      CODE_ADD:  ch = CH_ADD;
      CODE_SUB:  ch = CH_SUB;
      CODE_MUL:  ch = CH_MUL;
      CODE_DIV:  ch = CH_DIV;
      CODE_POW:  ch = CH_POW;
      default:   ch = CH_NUL;
    endcase
    return ch;
  endfunction

  function automatic logic [1:0] code_prec(input logic [2:0] code);
    logic [1:0] p;
    unique case (code)
      CODE_ADD, CODE_SUB: p = 2'd1;
      CODE_MUL, CODE_DIV: p = 2'd2;
      CODE_POW:           p = 2'd3;
      default:            p = 2'd0;
    endcase
    return p;
  endfunction

  function automatic logic is_letter(input logic [7:0] ch);
    return ((ch >= CH_UPPER_A) && (ch <= CH_UPPER_Z)) ||
           ((ch >= CH_LOWER_A) && (ch <= CH_LOWER_Z));
  endfunction

  function automatic logic is_operator(input logic [7:0] ch);
    return (ch == CH_ADD) || (ch == CH_SUB) || (ch == CH_MUL) ||
           (ch == CH_DIV) || (ch == CH_POW);
  endfunction

  function automatic logic [2:0] operator_code(input logic [7:0] ch);
    logic [2:0] code;
    unique case (ch)
      CH_ADD:  code = CODE_ADD;
      CH_SUB:  code = CODE_SUB;
      CH_MUL:  code = CODE_MUL;
      CH_DIV:  code = CODE_DIV;
      CH_POW:  code = CODE_POW;
      default: code = CODE_OPEN;
    endcase
    return code;
  endfunction

endpackage

FILE: src/itp_ram.sv
module itp_ram #(
  parameter int WIDTH = 3,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/infix_to_postfix_converter.sv
// Channel  Direction  Handshake                  Word
// in       input      in_valid_i / in_stall_o    symbol_in_i, end_of_expression_in_i
// out      output     out_valid_o / out_stall_i  symbol_out_o, run_last_o,
//                                                expression_done_o, overflow_seen_o
//
// One word at a time, accepted in IDLE; a letter, '(' or ignored byte goes IDLE, EXEC, IDLE.
// Each pop presents the top address in EXEC, then takes the registered RAM read in TOP. An end
// word pops every entry; ')' or an operator pops until it stops on an entry or the stack runs dry.
// Output stalls hold the block only where it must write its next result to the out channel.
// Reset (async, rst_ni low) empties the stack and clears the overflow flag.
module infix_to_postfix_converter #(
  parameter int STACK_DEPTH = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] symbol_in_i,
  input  logic       end_of_expression_in_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] symbol_out_o,
  output logic       run_last_o,
  output logic       expression_done_o,
  output logic       overflow_seen_o
);
  import itp_pkg::*;

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_TOP} state_e;
  typedef enum logic [2:0] {K_LETTER, K_OPEN, K_CLOSE, K_OP, K_END, K_NONE} item_kind_e;

  state_e     state_q, state_d;
  item_kind_e kind_q, kind_d;
  logic [7:0] sym_q, sym_d;
  logic [2:0] op_q, op_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic       ovf_q, ovf_d;
  // last popped operator, held back until we know whether it ends the run
  logic       pend_vld_q, pend_vld_d;
  logic [2:0] pend_code_q, pend_code_d;

  logic       out_valid_q, out_valid_d;
  logic [7:0] out_sym_q, out_sym_d;
  logic       out_last_q, out_last_d;
  logic       out_done_q, out_done_d;
  logic       out_ovf_q, out_ovf_d;

  logic          out_free;
  logic          we;
  logic [2:0]    wdata;
  logic [2:0]    top;
  logic [CW-1:0] cnt_dec;
  logic          stack_full;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign cnt_dec    = cnt_q - CW'(1);
  assign stack_full = (cnt_q >= CW'(STACK_DEPTH));

  itp_ram #(
    .WIDTH (3),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (cnt_q[AW-1:0]),
    .wdata_i (wdata),
    .raddr_i (cnt_dec[AW-1:0]),
    .rdata_o (top)
  );

  always_comb begin
    state_d     = state_q;
    kind_d      = kind_q;
    sym_d       = sym_q;
    op_d        = op_q;
    cnt_d       = cnt_q;
    ovf_d       = ovf_q;
    pend_vld_d  = pend_vld_q;
    pend_code_d = pend_code_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_sym_d   = out_sym_q;
    out_last_d  = out_last_q;
    out_done_d  = out_done_q;
    out_ovf_d   = out_ovf_q;
    we          = 1'b0;
    wdata       = op_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          sym_d      = symbol_in_i;
          op_d       = operator_code(symbol_in_i);
          pend_vld_d = 1'b0;
          state_d    = S_EXEC;
          priority if (end_of_expression_in_i) begin
            kind_d = K_END;
          end else if (is_letter(symbol_in_i)) begin
            kind_d = K_LETTER;
          end else if (symbol_in_i == CH_LPAREN) begin
            kind_d = K_OPEN;
          end else if (symbol_in_i == CH_RPAREN) begin
            kind_d = K_CLOSE;
          end else if (is_operator(symbol_in_i)) begin
            kind_d = K_OP;
          end else begin
            kind_d = K_NONE;
          end
        end
      end

      // stack top address is presented here; RAM data arrives in S_TOP
      S_EXEC: begin
        unique case (kind_q)
          K_LETTER: begin
            if (out_free) begin
              out_valid_d = 1'b1;
              out_sym_d   = sym_q;
              out_last_d  = 1'b1;
              out_done_d  = 1'b0;
              out_ovf_d   = 1'b0;
              state_d     = S_IDLE;
            end
          end
          K_OPEN: begin
            if (stack_full) begin
              ovf_d = 1'b1;
            end else begin
              we    = 1'b1;
              wdata = CODE_OPEN;
              cnt_d = cnt_q + CW'(1);
            end
            state_d = S_IDLE;
          end
          K_NONE: begin
            state_d = S_IDLE;
          end
          K_END: begin
            if (cnt_q != '0) begin
              state_d = S_TOP;
            end else if (out_free) begin
              out_valid_d = 1'b1;
              out_sym_d   = CH_NUL;
              out_last_d  = 1'b1;
              out_done_d  = 1'b1;
              out_ovf_d   = ovf_q;
              ovf_d       = 1'b0;
              state_d     = S_IDLE;
            end
          end
          K_CLOSE, K_OP: begin
            if (cnt_q != '0) begin
              state_d = S_TOP;
            end else if (!pend_vld_q || out_free) begin
              // stack ran dry: the held operator closes the run
              if (pend_vld_q) begin
                out_valid_d = 1'b1;
                out_sym_d   = code_char(pend_code_q);
                out_last_d  = 1'b1;
                out_done_d  = 1'b0;
                out_ovf_d   = 1'b0;
                pend_vld_d  = 1'b0;
              end
              if (kind_q == K_OP) begin
                we    = 1'b1;
                cnt_d = cnt_q + CW'(1);
              end
              state_d = S_IDLE;
            end
          end
          default: state_d = S_IDLE;
        endcase
      end

      S_TOP: begin
        unique case (kind_q)
          K_END: begin
            if (top == CODE_OPEN) begin
              cnt_d   = cnt_dec;
              state_d = S_EXEC;
            end else if (out_free) begin
              out_valid_d = 1'b1;
              out_sym_d   = code_char(top);
              out_last_d  = 1'b0;
              out_done_d  = 1'b0;
              out_ovf_d   = 1'b0;
              cnt_d       = cnt_dec;
              state_d     = S_EXEC;
            end
          end
          K_CLOSE, K_OP: begin
            if ((kind_q == K_CLOSE && top != CODE_OPEN) ||
                (kind_q == K_OP && code_prec(top) >= code_prec(op_q))) begin
              // keep popping: previous held operator is not the last word
              if (!pend_vld_q || out_free) begin
                if (pend_vld_q) begin
                  out_valid_d = 1'b1;
                  out_sym_d   = code_char(pend_code_q);
                  out_last_d  = 1'b0;
                  out_done_d  = 1'b0;
                  out_ovf_d   = 1'b0;
                end
                pend_vld_d  = 1'b1;
                pend_code_d = top;
                cnt_d       = cnt_dec;
                state_d     = S_EXEC;
              end
            end else if (!pend_vld_q || out_free) begin
              if (pend_vld_q) begin
                out_valid_d = 1'b1;
                out_sym_d   = code_char(pend_code_q);
                out_last_d  = 1'b1;
                out_done_d  = 1'b0;
                out_ovf_d   = 1'b0;
                pend_vld_d  = 1'b0;
              end
              if (kind_q == K_CLOSE) begin
                cnt_d = cnt_dec;  // drop the matching '('
              end else if (stack_full) begin
                ovf_d = 1'b1;
              end else begin
                we    = 1'b1;
                cnt_d = cnt_q + CW'(1);
              end
              state_d = S_IDLE;
            end
          end
          default: state_d = S_IDLE;
        endcase
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      kind_q      <= K_NONE;
      sym_q       <= CH_NUL;
      op_q        <= CODE_OPEN;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      pend_vld_q  <= 1'b0;
      pend_code_q <= CODE_OPEN;
      out_valid_q <= 1'b0;
      out_sym_q   <= CH_NUL;
      out_last_q  <= 1'b0;
      out_done_q  <= 1'b0;
      out_ovf_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      kind_q      <= kind_d;
      sym_q       <= sym_d;
      op_q        <= op_d;
      cnt_q       <= cnt_d;
      ovf_q       <= ovf_d;
      pend_vld_q  <= pend_vld_d;
      pend_code_q <= pend_code_d;
      out_valid_q <= out_valid_d;
      out_sym_q   <= out_sym_d;
      out_last_q  <= out_last_d;
      out_done_q  <= out_done_d;
      out_ovf_q   <= out_ovf_d;
    end
  end

  assign in_stall_o        = (state_q != S_IDLE);
  assign out_valid_o       = out_valid_q;
  assign symbol_out_o      = out_sym_q;
  assign run_last_o        = out_last_q;
  assign expression_done_o = out_done_q;
  assign overflow_seen_o   = out_ovf_q;

endmodule

FILE: verif/tb_infix_to_postfix_converter.sv
module tb_infix_to_postfix_converter;
  import itp_pkg::*;

  localparam int STACK_DEPTH  = 32;
  // worst drain: a full stack of pops plus decode, with margin
  localparam int SETTLE_CYCLES = 2 * STACK_DEPTH + 8;
  localparam int RANDOM_WORDS  = 40;

  typedef struct packed {
    logic [7:0] sym;
    logic       run_end;
    logic       done;
    logic       ovf;
  } postfix_word_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [7:0] symbol_in_i = 8'h00;
  logic       end_of_expression_in_i = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [7:0] symbol_out_o;
  logic       run_last_o;
  logic       expression_done_o;
  logic       overflow_seen_o;

  // predictor state
  logic [2:0]    op_stack [STACK_DEPTH];
  int            stack_fill = 0;
  logic          ovf_flag = 1'b0;
  postfix_word_t pending_out [$];

  int mismatch_count = 0;
  int useful_words = 0;
  bit idle_en = 1'b1;
  int stall_left = 0;

  infix_to_postfix_converter #(
    .STACK_DEPTH(STACK_DEPTH)
  ) dut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .in_valid_i            (in_valid_i),
    .in_stall_o            (in_stall_o),
    .symbol_in_i           (symbol_in_i),
    .end_of_expression_in_i(end_of_expression_in_i),
    .out_valid_o           (out_valid_o),
    .out_stall_i           (out_stall_i),
    .symbol_out_o          (symbol_out_o),
    .run_last_o            (run_last_o),
    .expression_done_o     (expression_done_o),
    .overflow_seen_o       (overflow_seen_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int pick_gap();
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 20);
    return $urandom_range(1, 3);
  endfunction

  function automatic logic [7:0] sym_of_code(input logic [2:0] code);
    case (code)
      CODE_ADD: return CH_ADD;
      CODE_SUB: return CH_SUB;
      CODE_MUL: return CH_MUL;
      CODE_DIV: return CH_DIV;
      CODE_POW: return CH_POW;
      default:  return CH_LPAREN;
    endcase
  endfunction

  function automatic int rank_of_code(input logic [2:0] code);
    case (code)
      CODE_ADD, CODE_SUB: return 1;
      CODE_MUL, CODE_DIV: return 2;
      CODE_POW:           return 3;
      default:            return 0;
    endcase
  endfunction

  function automatic logic [2:0] code_of_sym(input logic [7:0] sym);
    case (sym)
      CH_ADD:  return CODE_ADD;
      CH_SUB:  return CODE_SUB;
      CH_MUL:  return CODE_MUL;
      CH_DIV:  return CODE_DIV;
      CH_POW:  return CODE_POW;
      default: return CODE_OPEN;
    endcase
  endfunction

  task automatic queue_result(input logic [7:0] sym, input logic done, input logic ovf);
    postfix_word_t w;
    w.sym     = sym;
    w.run_end = 1'b0;
    w.done    = done;
    w.ovf     = ovf;
    pending_out.push_back(w);
  endtask

  task automatic push_code(input logic [2:0] code);
    if (stack_fill >= STACK_DEPTH) begin
      ovf_flag = 1'b1;
    end else begin
      op_stack[stack_fill] = code;
      stack_fill++;
    end
  endtask

  // Shunting-yard step for one accepted word; queues the postfix words it causes.
  task automatic predict_postfix(input logic [7:0] sym, input logic eoe);
    int         n;
    logic [2:0] code;
    n = 0;
    if (eoe) begin
      while (stack_fill > 0) begin
        stack_fill--;
        if (op_stack[stack_fill] != CODE_OPEN) begin
          queue_result(sym_of_code(op_stack[stack_fill]), 1'b0, 1'b0);
          n++;
        end
      end
      queue_result(CH_NUL, 1'b1, ovf_flag);
      n++;
      ovf_flag = 1'b0;
      useful_words++;
    end else begin
      case (sym)
        CH_LPAREN: begin
          push_code(CODE_OPEN);
          useful_words++;
        end
        CH_RPAREN: begin
          while (stack_fill > 0 && op_stack[stack_fill-1] != CODE_OPEN) begin
            queue_result(sym_of_code(op_stack[stack_fill-1]), 1'b0, 1'b0);
            n++;
            stack_fill--;
          end
          if (stack_fill > 0) stack_fill--;
          useful_words++;
        end
        CH_ADD, CH_SUB, CH_MUL, CH_DIV, CH_POW: begin
          code = code_of_sym(sym);
          while (stack_fill > 0 &&
                 rank_of_code(op_stack[stack_fill-1]) >= rank_of_code(code)) begin
            queue_result(sym_of_code(op_stack[stack_fill-1]), 1'b0, 1'b0);
            n++;
            stack_fill--;
          end
          push_code(code);
          useful_words++;
        end
        default: begin
          if ((sym >= CH_UPPER_A && sym <= CH_UPPER_Z) ||
              (sym >= CH_LOWER_A && sym <= CH_LOWER_Z)) begin
            queue_result(sym, 1'b0, 1'b0);
            n++;
            useful_words++;
          end
        end
      endcase
    end
    if (n > 0) pending_out[pending_out.size()-1].run_end = 1'b1;
  endtask

  // valid is only lowered when a gap follows, so it is never dropped and raised in one step
  task automatic send_word(input logic [7:0] sym, input logic eoe);
    int gap;
    gap = (idle_en && $urandom_range(0, 1) == 0) ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i             <= 1'b1;
    symbol_in_i            <= sym;
    end_of_expression_in_i <= eoe;
    do @(posedge clk_i); while (in_stall_o);
    predict_postfix(sym, eoe);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_word(s[i], 1'b0);
  endtask

  task automatic hold_until_drained();
    in_valid_i <= 1'b0;
    while (pending_out.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic check_field(input string name, input logic [7:0] exp_v,
                             input logic [7:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s expected %h, got %h", $time, name, exp_v, act_v);
      mismatch_count++;
    end
  endtask

  always @(posedge clk_i) begin
    postfix_word_t w;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_out.size() == 0) begin
        $display("%0t: unexpected word expected none, got sym %h last %b done %b ovf %b",
                 $time, symbol_out_o, run_last_o, expression_done_o, overflow_seen_o);
        mismatch_count++;
      end else begin
        w = pending_out.pop_front();
        check_field("symbol_out", w.sym, symbol_out_o);
        check_field("run_last", {7'b0, w.run_end}, {7'b0, run_last_o});
        check_field("expression_done", {7'b0, w.done}, {7'b0, expression_done_o});
        check_field("overflow_seen", {7'b0, w.ovf}, {7'b0, overflow_seen_o});
      end
    end
  end

  // output back-pressure
  always @(posedge clk_i) begin
    if (!idle_en) begin
      out_stall_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if ($urandom_range(0, 3) == 0) begin
      stall_left = pick_gap() - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  function automatic logic [7:0] random_letter();
    if ($urandom_range(0, 1) == 0) return CH_UPPER_A + 8'($urandom_range(0, 25));
    return CH_LOWER_A + 8'($urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] random_operator();
    case ($urandom_range(0, 4))
      0:       return CH_ADD;
      1:       return CH_SUB;
      2:       return CH_MUL;
      3:       return CH_DIV;
      default: return CH_POW;
    endcase
  endfunction

  // letter bounds and bytes around them that must be ignored
  task automatic test_symbol_classes();
    send_word(CH_UPPER_A, 1'b0);
    send_word(CH_UPPER_Z, 1'b0);
    send_word(CH_LOWER_A, 1'b0);
    send_word(CH_LOWER_Z, 1'b0);
    send_word(8'h40, 1'b0);
    send_word(8'h5B, 1'b0);
    send_word(8'h60, 1'b0);
    send_word(8'h7B, 1'b0);
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b0);
    // symbol on an end word is ignored
    send_word(CH_ADD, 1'b1);
  endtask

  // all operators, mixed precedence, ^ chained left to right
  task automatic test_precedence();
    send_text("a+B*c^d^e-f/g 1");
    send_word(8'hA5, 1'b1);
  endtask

  // stray ')' pops the rest, a '(' left open is dropped in the flush
  task automatic test_parentheses();
    send_text(")a*(b-c))/(");
    send_word(8'h5A, 1'b1);
  endtask

  task automatic test_stack_full();
    idle_en = 1'b0;
    for (int i = 0; i < STACK_DEPTH / 2; i++) send_text("(+");
    send_word(CH_POW, 1'b0);     // dropped, stack full
    send_word(CH_LPAREN, 1'b0);  // dropped
    send_word(CH_SUB, 1'b0);     // pops '+' first, then fits
    send_word(CH_LOWER_Z, 1'b0);
    send_word(CH_RPAREN, 1'b0);
    idle_en = 1'b1;
    send_word(8'h00, 1'b1);
    send_word(8'hFF, 1'b1);      // flag must be clear again
    hold_until_drained();
  endtask

  task automatic send_random_expression();
    int operands;
    int open_n;
    operands = $urandom_range(1, 6);
    open_n = 0;
    for (int i = 0; i < operands; i++) begin
      while ($urandom_range(0, 3) == 0 && open_n < 12) begin
        send_word(CH_LPAREN, 1'b0);
        open_n++;
      end
      send_word(random_letter(), 1'b0);
      if ($urandom_range(0, 9) == 0) send_word(8'($urandom_range(0, 255)), 1'b0);
      while (open_n > 0 && $urandom_range(0, 2) == 0) begin
        send_word(CH_RPAREN, 1'b0);
        open_n--;
      end
      if (i < operands - 1) begin
        send_word(random_operator(), 1'b0);
        if ($urandom_range(0, 19) == 0) send_word(random_operator(), 1'b0);
      end
    end
    // most expressions close cleanly; some leave '(' open or add a stray ')'
    if ($urandom_range(0, 4) != 0) begin
      while (open_n > 0) begin
        send_word(CH_RPAREN, 1'b0);
        open_n--;
      end
    end else if ($urandom_range(0, 1) == 0) begin
      send_word(CH_RPAREN, 1'b0);
    end
    send_word(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic test_random_expressions();
    int start;
    start = useful_words;
    while (useful_words - start < RANDOM_WORDS) begin
      idle_en = ($urandom_range(0, 4) != 0);
      send_random_expression();
      if ($urandom_range(0, 3) == 0) hold_until_drained();
    end
    idle_en = 1'b1;
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_symbol_classes();
    test_precedence();
    test_parentheses();
    test_stack_full();
    test_random_expressions();
    hold_until_drained();
    if (mismatch_count == 0 && pending_out.size() == 0) begin
      $display("tb_infix_to_postfix_converter: PASS");
    end else begin
      $display("tb_infix_to_postfix_converter: FAIL");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("tb_infix_to_postfix_converter: FAIL");
    $finish;
  end

endmodule
